/* sv/packet_deframe_xor_chain_decode_assert.svh */
// ----------------------------------------------------------------------------
// packet_deframe_xor_chain_decode_assert.svh
// Assertion macros used by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAME_XOR_CHAIN_DECODE_ASSERT_SVH
`define PACKET_DEFRAME_XOR_CHAIN_DECODE_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet in reset.
`define PDXC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, clocked on clk, quiet in reset.
`define PDXC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

/* sv/pdxc_pkg.sv */
// ----------------------------------------------------------------------------
// pdxc_pkg
// Phase and status codes of the packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package pdxc_pkg;

    typedef logic [2:0] phase_t;
    typedef logic [1:0] status_t;
    typedef logic [1:0] cfg_index_t;

    localparam phase_t PH_START   = 3'd0;
    localparam phase_t PH_LEN_LO  = 3'd1;
    localparam phase_t PH_LEN_HI  = 3'd2;
    localparam phase_t PH_KEY     = 3'd3;
    localparam phase_t PH_CHECK   = 3'd4;
    localparam phase_t PH_PAYLOAD = 3'd5;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_SUM  = 2'd1;
    localparam status_t ST_CODE = 2'd2;
    localparam status_t ST_LEN  = 2'd3;

    localparam cfg_index_t CFG_START_CODE = 2'd0;
    localparam cfg_index_t CFG_FIXED_KEY  = 2'd1;
    localparam cfg_index_t CFG_MAX_LEN    = 2'd2;

endpackage

`default_nettype wire

/* sv/packet_deframe_xor_chain_decode.sv */
// ----------------------------------------------------------------------------
// packet_deframe_xor_chain_decode
// Header check and two-stage chained XOR decode of a framed byte stream.
// ----------------------------------------------------------------------------
//  channel | signals                                   | role
//  --------+-------------------------------------------+------------------------
//  in      | in_valid, in_ready, stream_byte           | one stream byte a beat
//  out     | out_valid, out_ready, data, data_valid,   | decoded byte or end /
//          | last, status                              | error report a beat
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata           | register writes
//
// One byte a cycle while in_ready is high: decode and header checks sit
// between the phase registers and a single result register, so a byte's
// result shows the cycle after it is taken. in_ready is low only while a
// result is held and out_ready is low. rst_n clears phase, chain state and
// result valid; keys reset to zero and max_len_reg to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_deframe_xor_chain_decode
    import pdxc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire cfg_index_t  cfg_index,
    input  wire logic [15:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  stream_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       data,
    output logic             data_valid,
    output logic             last,
    output status_t          status
);

    logic [7:0]  start_code_reg;
    logic [7:0]  fixed_key_reg;
    logic [15:0] max_len_reg;

    phase_t      phase_reg,     phase_next;
    logic [15:0] payload_len_reg, payload_len_next;
    logic [16:0] byte_index_reg, byte_index_next;
    logic [7:0]  packet_key_reg, packet_key_next;
    logic [7:0]  prev_enc_reg,  prev_enc_next;
    logic [7:0]  prev_s1_reg,   prev_s1_next;
    logic [7:0]  exp_sum_reg,   exp_sum_next;
    logic [7:0]  run_sum_reg,   run_sum_next;

    logic        out_valid_reg;
    logic [7:0]  data_reg;
    logic        data_valid_reg;
    logic        last_reg;
    status_t     status_reg;

    logic        in_fire;
    logic        res_fire;
    logic [7:0]  res_data;
    logic        res_data_valid;
    logic        res_last;
    status_t     res_status;

    logic [7:0]  step;
    logic [7:0]  s1;
    logic [7:0]  dec;
    logic [16:0] idx_inc;
    logic [15:0] len_full;
    logic [7:0]  sum_inc;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign step     = byte_index_reg[7:0] + 8'd1;
    assign s1       = stream_byte ^ (prev_enc_reg + fixed_key_reg + step);
    assign dec      = s1 ^ (prev_s1_reg + packet_key_reg + step);
    assign idx_inc  = byte_index_reg + 17'd1;
    assign len_full = {stream_byte, payload_len_reg[7:0]};
    assign sum_inc  = run_sum_reg + dec;

    always_comb
    begin
        phase_next       = phase_reg;
        payload_len_next = payload_len_reg;
        byte_index_next  = byte_index_reg;
        packet_key_next  = packet_key_reg;
        prev_enc_next    = prev_enc_reg;
        prev_s1_next     = prev_s1_reg;
        exp_sum_next     = exp_sum_reg;
        run_sum_next     = run_sum_reg;
        res_fire         = 1'b0;
        res_data         = 8'd0;
        res_data_valid   = 1'b0;
        res_last         = 1'b0;
        res_status       = ST_OK;

        unique case (phase_reg)
            PH_LEN_LO:
            begin
                payload_len_next = {8'd0, stream_byte};
                phase_next       = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                payload_len_next = len_full;
                if (len_full > max_len_reg)
                begin
                    phase_next = PH_START;
                    res_fire   = 1'b1;
                    res_last   = 1'b1;
                    res_status = ST_LEN;
                end
                else
                begin
                    phase_next = PH_KEY;
                end
            end
            PH_KEY:
            begin
                packet_key_next = stream_byte;
                byte_index_next = 17'd0;
                prev_enc_next   = 8'd0;
                prev_s1_next    = 8'd0;
                run_sum_next    = 8'd0;
                phase_next      = PH_CHECK;
            end
            PH_CHECK:
            begin
                exp_sum_next    = dec;
                prev_enc_next   = stream_byte;
                prev_s1_next    = s1;
                byte_index_next = idx_inc;
                if (payload_len_reg == 16'd0)
                begin
                    phase_next = PH_START;
                    res_fire   = 1'b1;
                    res_last   = 1'b1;
                    res_status = (dec == 8'd0) ? ST_OK : ST_SUM;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                prev_enc_next   = stream_byte;
                prev_s1_next    = s1;
                byte_index_next = idx_inc;
                run_sum_next    = sum_inc;
                res_fire        = 1'b1;
                res_data        = dec;
                res_data_valid  = 1'b1;
                if (idx_inc > {1'b0, payload_len_reg})
                begin
                    phase_next = PH_START;
                    res_last   = 1'b1;
                    res_status = (sum_inc == exp_sum_reg) ? ST_OK : ST_SUM;
                end
            end
            default:
            begin
                // start hunt; unused codes land here too
                if (stream_byte != start_code_reg)
                begin
                    phase_next = PH_START;
                    res_fire   = 1'b1;
                    res_last   = 1'b1;
                    res_status = ST_CODE;
                end
                else
                begin
                    phase_next = PH_LEN_LO;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= 8'd0;
            fixed_key_reg  <= 8'd0;
            max_len_reg    <= 16'hFFFF;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_START_CODE: start_code_reg <= cfg_wdata[7:0];
                CFG_FIXED_KEY:  fixed_key_reg  <= cfg_wdata[7:0];
                CFG_MAX_LEN:    max_len_reg    <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            payload_len_reg <= 16'd0;
            byte_index_reg  <= 17'd0;
            packet_key_reg  <= 8'd0;
            prev_enc_reg    <= 8'd0;
            prev_s1_reg     <= 8'd0;
            exp_sum_reg     <= 8'd0;
            run_sum_reg     <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            payload_len_reg <= payload_len_next;
            byte_index_reg  <= byte_index_next;
            packet_key_reg  <= packet_key_next;
            prev_enc_reg    <= prev_enc_next;
            prev_s1_reg     <= prev_s1_next;
            exp_sum_reg     <= exp_sum_next;
            run_sum_reg     <= run_sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && res_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_fire)
        begin
            data_reg       <= res_data;
            data_valid_reg <= res_data_valid;
            last_reg       <= res_last;
            status_reg     <= res_status;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data       = data_reg;
    assign data_valid = data_valid_reg;
    assign last       = last_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

/* sv/pdxc_checker.sv */
// ----------------------------------------------------------------------------
// pdxc_checker
// Port-level checks on the deframer's result channel and in_ready, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_deframe_xor_chain_decode_assert.svh"

module pdxc_checker
    import pdxc_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [7:0]  data,
    input wire logic        data_valid,
    input wire logic        last,
    input wire status_t     status
);

    logic [11:0] held_beat;

    assign held_beat = {data, data_valid, last, status};

    // held beat stays put
    `PDXC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(held_beat))
    // a beat without data always closes a packet or reports an error
    `PDXC_ASSERT_NOW(a_nodata_last, out_valid && !data_valid, last && data == 8'd0)
    // non-final beats carry ok status
    `PDXC_ASSERT_NOW(a_mid_ok, out_valid && !last, status == ST_OK && data_valid)
    // header errors never carry data
    `PDXC_ASSERT_NOW(a_err_nodata, out_valid && (status == ST_CODE || status == ST_LEN), !data_valid)
    // input is only stalled behind an unaccepted beat
    `PDXC_ASSERT_NOW(a_ready, !in_ready, out_valid && !out_ready)

endmodule

bind packet_deframe_xor_chain_decode pdxc_checker u_pdxc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .data       (data),
    .data_valid (data_valid),
    .last       (last),
    .status     (status)
);

`default_nettype wire
